FILE: rtl/tctd_pkg.sv
// shared types, constants and codes for the two-color tile encoder with tile table
`default_nettype none

package tctd_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int TILE_ROWS   = 8;
    localparam int PIX_PER_ROW = 8;
    localparam int PIX_W       = 4;
    localparam int ROW_BITS    = 8;
    localparam int WORD_W      = TILE_ROWS * ROW_BITS;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ROW_W = $clog2(TILE_ROWS);

    typedef enum logic [0:0] {
        KIND_ROW   = 1'b0,
        KIND_CLEAR = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_MULTI = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] row_pixels;
    } req_t;

    typedef struct packed {
        logic [7:0] tile_index;
        logic       is_new;
        status_t    status;
        logic [8:0] tile_count;
    } rsp_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] pattern;
        logic [ROW_BITS-1:0] color;
        logic                bad;
    } row_code_t;

    typedef struct packed {
        logic [WORD_W-1:0] pattern;
        logic [WORD_W-1:0] color;
    } entry_t;

    typedef struct packed {
        logic   failed;
        entry_t entry;
    } tile_t;

endpackage

`default_nettype wire

FILE: rtl/tctd_tile_acc.sv
// row encoder and tile accumulator: pattern and color words, row counter, failed flag
`default_nettype none

module tctd_tile_acc (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      row_en,
    input  wire logic                      clear,
    input  wire logic [31:0]               pixels,
    output      logic                      last_row,
    output      tctd_pkg::tile_t           tile
);

    logic [tctd_pkg::WORD_W-1:0] pattern_reg, pattern_next;
    logic [tctd_pkg::WORD_W-1:0] color_reg, color_next;
    logic                        failed_reg, failed_next;
    logic [tctd_pkg::ROW_W-1:0]  row_reg, row_next;
    tctd_pkg::row_code_t         code;

    function automatic tctd_pkg::row_code_t encode_row(input logic [31:0] pix);
        logic [tctd_pkg::PIX_W-1:0] first;
        logic [tctd_pkg::PIX_W-1:0] second;
        logic [tctd_pkg::PIX_W-1:0] c;
        logic                       have;
        tctd_pkg::row_code_t        rc;
        first  = pix[tctd_pkg::PIX_W-1:0];
        second = '0;
        have   = 1'b0;
        rc     = '0;
        for (int x = 0; x < tctd_pkg::PIX_PER_ROW; x++)
        begin
            c = pix[tctd_pkg::PIX_W*x +: tctd_pkg::PIX_W];
            if (c != first)
            begin
                rc.pattern[tctd_pkg::PIX_PER_ROW-1-x] = 1'b1;
                if (!have)
                begin
                    second = c;
                    have   = 1'b1;
                end
                else if (c != second)
                begin
                    rc.bad = 1'b1;
                end
            end
        end
        rc.color = {second, first};
        return rc;
    endfunction

    assign last_row = (row_reg == tctd_pkg::ROW_W'(tctd_pkg::TILE_ROWS - 1));
    assign code     = encode_row(pixels);

    always_comb
    begin
        pattern_next = pattern_reg;
        color_next   = color_reg;
        failed_next  = failed_reg;
        row_next     = row_reg;
        if (clear)
        begin
            row_next    = '0;
            failed_next = 1'b0;
        end
        else if (row_en)
        begin
            // first row of a tile starts fresh words
            if (row_reg == '0)
            begin
                pattern_next = '0;
                color_next   = '0;
                failed_next  = code.bad;
            end
            else
            begin
                failed_next = failed_reg | code.bad;
            end
            pattern_next[tctd_pkg::ROW_BITS*row_reg +: tctd_pkg::ROW_BITS] = code.pattern;
            color_next[tctd_pkg::ROW_BITS*row_reg +: tctd_pkg::ROW_BITS]   = code.color;
            row_next = last_row ? '0 : row_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            failed_reg <= 1'b0;
        end
        else
        begin
            row_reg    <= row_next;
            failed_reg <= failed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pattern_reg <= pattern_next;
        color_reg   <= color_next;
    end

    assign tile.failed        = failed_reg;
    assign tile.entry.pattern = pattern_reg;
    assign tile.entry.color   = color_reg;

endmodule

`default_nettype wire

FILE: rtl/tctd_tile_ram.sv
// tile table memory: one write port, one read port with registered read data
`default_nettype none

module tctd_tile_ram (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [tctd_pkg::IDX_W-1:0] waddr,
    input  wire tctd_pkg::entry_t           wdata,
    input  wire logic [tctd_pkg::IDX_W-1:0] raddr,
    output      tctd_pkg::entry_t           rdata
);

    tctd_pkg::entry_t mem [tctd_pkg::TABLE_DEPTH];
    tctd_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/two_color_tile_encode_dedup.sv
// top level: row intake, sequential table search, append and result register
//
// channel   direction  handshake              word
// req       in         req_valid / req_ready  tctd_pkg::req_t (kind, row_pixels)
// rsp       out        rsp_valid / rsp_ready  tctd_pkg::rsp_t (index, new, status, count)
//
// rows and clears are taken only in the idle state; rows 1..7 of a tile give no word
// the eighth row starts a scan of the table through its single read port:
// one entry per cycle, then the outcome is loaded into the result register
// reset clears control state and the tile count; the memory is never swept
// a waiting result holds only the emit step; rows keep flowing while rsp stalls
// until the next tile reaches the emit step
`default_nettype none

module two_color_tile_encode_dedup (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output      logic             req_ready,
    input  wire tctd_pkg::req_t   req,
    output      logic             rsp_valid,
    input  wire logic             rsp_ready,
    output      tctd_pkg::rsp_t   rsp
);

    tctd_pkg::state_t             state_reg, state_next;
    logic [tctd_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [tctd_pkg::CNT_W-1:0]   scan_reg, scan_next;
    logic                         pend_reg, pend_next;
    logic [tctd_pkg::IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    tctd_pkg::rsp_t               res_reg, res_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    tctd_pkg::rsp_t               rsp_reg, rsp_next;

    logic                         accept;
    logic                         is_clear;
    logic                         last_row;
    logic                         hit;
    logic                         ram_we;
    tctd_pkg::tile_t              tile;
    tctd_pkg::entry_t             rdata;

    assign req_ready = (state_reg == tctd_pkg::ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign is_clear  = (req.kind == tctd_pkg::KIND_CLEAR);

    tctd_tile_acc u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .row_en   (accept && !is_clear),
        .clear    (accept && is_clear),
        .pixels   (req.row_pixels),
        .last_row (last_row),
        .tile     (tile)
    );

    tctd_tile_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[tctd_pkg::IDX_W-1:0]),
        .wdata (tile.entry),
        .raddr (scan_reg[tctd_pkg::IDX_W-1:0]),
        .rdata (rdata)
    );

    assign hit = pend_reg && (rdata == tile.entry);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        unique case (state_reg)
            tctd_pkg::ST_IDLE:
            begin
                scan_next = '0;
                if (accept)
                begin
                    if (is_clear)
                    begin
                        count_next = '0;
                    end
                    else if (last_row)
                    begin
                        state_next = tctd_pkg::ST_SEARCH;
                    end
                end
            end
            tctd_pkg::ST_SEARCH:
            begin
                res_next.tile_index = '0;
                res_next.is_new     = 1'b0;
                res_next.status     = tctd_pkg::STATUS_OK;
                res_next.tile_count = 9'(count_reg);
                if (tile.failed)
                begin
                    res_next.status = tctd_pkg::STATUS_MULTI;
                    state_next      = tctd_pkg::ST_EMIT;
                end
                else if (hit)
                begin
                    res_next.tile_index = 8'(pend_idx_reg);
                    state_next          = tctd_pkg::ST_EMIT;
                end
                else if (scan_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[tctd_pkg::IDX_W-1:0];
                    scan_next     = scan_reg + 1'b1;
                end
                else
                begin
                    // no match: append if room is left
                    if (count_reg != tctd_pkg::CNT_W'(tctd_pkg::TABLE_DEPTH))
                    begin
                        ram_we              = 1'b1;
                        count_next          = count_reg + 1'b1;
                        res_next.tile_index = 8'(count_reg);
                        res_next.is_new     = 1'b1;
                        res_next.tile_count = 9'(count_reg + 1'b1);
                    end
                    else
                    begin
                        res_next.status = tctd_pkg::STATUS_FULL;
                    end
                    state_next = tctd_pkg::ST_EMIT;
                end
            end
            tctd_pkg::ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = tctd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tctd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tctd_pkg::ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_pend_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == tctd_pkg::ST_SEARCH)
        else $error("compare pending outside search");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tctd_pkg::CNT_W'(tctd_pkg::TABLE_DEPTH))
        else $error("tile count beyond table depth");

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == tctd_pkg::ST_SEARCH && !tile.failed && !hit)
        else $error("table write outside a missed search");

    a_last_row_search: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_clear && last_row |=> state_reg == tctd_pkg::ST_SEARCH)
        else $error("eighth row did not start a search");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tctd_pkg::ST_SEARCH |=>
            count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1'b1)
        else $error("tile count moved by more than one");

endmodule

`default_nettype wire
